@@ rtl/ccell_pkg.sv @@
// shared types and constants of the cardiac cell euler step block
package ccell_pkg;

    // fraction bits of the signed fixed-point cell values
    localparam int FRAC_BITS = 24;

    // initial cell values at 24 fraction bits
    localparam logic [31:0] INIT_V_Q24 = 32'd138;
    localparam logic [31:0] INIT_H_Q24 = 32'd14746593;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STIM_FIRST = 3'd0,
        CFG_STIM_LAST  = 3'd1,
        CFG_STIM_CELLS = 3'd2,
        CFG_STIM_AMP   = 3'd3,
        CFG_TIME_STEP  = 3'd4,
        CFG_WATCH_CELL = 3'd5
    } ccell_cfg_idx_t;

    localparam logic [15:0] STIM_FIRST_RST = 16'd0;
    localparam logic [15:0] STIM_LAST_RST  = 16'd50;
    localparam logic [5:0]  STIM_CELLS_RST = 6'd5;
    localparam logic [31:0] STIM_AMP_RST   = 32'd16777216;
    localparam logic [24:0] TIME_STEP_RST  = 25'd335544;
    localparam logic [4:0]  WATCH_CELL_RST = 5'd1;

    // controller to datapath
    typedef struct packed {
        logic load_init;
        logic rd_watch;
        logic out_load;
        logic rd_cell;
        logic finish;
    } ccell_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } ccell_sts_t;

endpackage

@@ rtl/cardiac_cell_euler_step.sv @@
// top level of the cardiac cell array, one forward euler step per advancing item
//
// usage:
//   in channel (in_valid/in_ready, restart): each item is one time tick.
//   restart=1 reloads all cells and the step index, restart=0 advances every
//   cell by one step. out channel (out_valid/out_ready) returns one item per
//   tick: step index and the watched cell's values from before the update.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the stimulus,
//   time step and watched cell settings; cfg_ready is always high, write only
//   while no tick is in progress.
//   result: after an input item is accepted, the watched cell is read and the
//   result is loaded into the output register once that register is free. A
//   restart item ends there; an advancing item then sweeps one cell per cycle
//   through the single read port of the cell memories into the update pipeline
//   and waits for it to drain. A new item is accepted only after the last ends.
//   reset: settings take their defaults, every cell reads as its initial
//   value and the step index is zero; no clearing pass is needed.
//   receiver stall: the result stays in the output register; a following
//   tick is accepted but holds its result until the register is free.
module cardiac_cell_euler_step
    import ccell_pkg::*;
#(
    parameter int NUM_CELLS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 restart,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [15:0]          step_index,
    output logic signed [31:0]   watched_voltage,
    output logic signed [31:0]   watched_gate,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int CW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

    ccell_cmd_t    cmd;
    ccell_sts_t    sts;
    logic [CW-1:0] cell_idx;

    assign cfg_ready = 1'b1;

    ccell_ctrl #(
        .NUM_CELLS (NUM_CELLS),
        .CW        (CW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .restart  (restart),
        .cmd      (cmd),
        .cell_idx (cell_idx),
        .sts      (sts)
    );

    ccell_dp #(
        .NUM_CELLS (NUM_CELLS),
        .CW        (CW)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .cell_idx        (cell_idx),
        .sts             (sts),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .step_index      (step_index),
        .watched_voltage (watched_voltage),
        .watched_gate    (watched_gate)
    );

endmodule

@@ rtl/ccell_cdiv.sv @@
// pipelined signed divide by a constant, truncating toward zero, three stages
module ccell_cdiv #(
    parameter int unsigned DIVISOR = 3
) (
    input  logic               clk,
    input  logic signed [31:0] x,
    output logic signed [31:0] q
);

    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(DIVISOR));
    localparam int RW = $clog2(DIVISOR) + 2;

    logic        neg1_reg;
    logic [31:0] mag1_reg;
    logic        neg2_reg;
    logic [31:0] mag2_reg;
    logic [63:0] prod2_reg;
    logic signed [31:0] q_reg;

    logic [31:0]   mag1_next;
    logic [31:0]   q0;
    logic [RW-1:0] rem;
    logic [31:0]   qa;
    logic signed [31:0] q_next;

    always_comb
    begin
        mag1_next = x[31] ? 32'(~x + 1'b1) : 32'(x);
        q0        = prod2_reg[63:32];
        // estimate is low by at most one
        rem       = RW'(mag2_reg) - RW'(q0) * RW'(DIVISOR);
        qa        = q0 + 32'(rem >= RW'(DIVISOR));
        q_next    = neg2_reg ? -$signed(qa) : $signed(qa);
    end

    always_ff @(posedge clk)
    begin
        neg1_reg  <= x[31];
        mag1_reg  <= mag1_next;
        neg2_reg  <= neg1_reg;
        mag2_reg  <= mag1_reg;
        prod2_reg <= 64'(mag1_reg) * 64'(RECIP);
        q_reg     <= q_next;
    end

    assign q = q_reg;

endmodule

@@ rtl/ccell_ctrl.sv @@
// sequencing controller: accept, watched read, result load, cell sweep, drain
module ccell_ctrl
    import ccell_pkg::*;
#(
    parameter int NUM_CELLS = 32,
    parameter int CW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          restart,
    output ccell_cmd_t    cmd,
    output logic [CW-1:0] cell_idx,
    input  ccell_sts_t    sts
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_WATCH  = 5'b00010,
        ST_RESULT = 5'b00100,
        ST_SWEEP  = 5'b01000,
        ST_DRAIN  = 5'b10000
    } ccell_state_t;

    localparam logic [CW-1:0] LAST_CELL = CW'(NUM_CELLS - 1);

    ccell_state_t  state_reg, state_next;
    logic          restart_reg, restart_next;
    logic [CW-1:0] cell_cnt_reg, cell_cnt_next;

    always_comb
    begin
        state_next    = state_reg;
        restart_next  = restart_reg;
        cell_cnt_next = cell_cnt_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_init = restart;
                    restart_next  = restart;
                    state_next    = ST_WATCH;
                end
            end
            ST_WATCH:
            begin
                cmd.rd_watch = 1'b1;
                state_next   = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cell_cnt_next = '0;
                    state_next    = restart_reg ? ST_IDLE : ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                cmd.rd_cell = 1'b1;
                if (cell_cnt_reg == LAST_CELL)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cell_cnt_next = cell_cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            restart_reg  <= 1'b0;
            cell_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            restart_reg  <= restart_next;
            cell_cnt_reg <= cell_cnt_next;
        end
    end

    assign cell_idx = cell_cnt_reg;

`ifndef ASSERT_OFF
    a_accept_to_watch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_WATCH))
        else $error("accepted item did not start a watched read");
    a_sweep_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP && cell_cnt_reg != LAST_CELL) |=>
        (state_reg == ST_SWEEP && cell_cnt_reg == CW'($past(cell_cnt_reg) + 1'b1)))
        else $error("cell sweep skipped or repeated a cell");
`endif

endmodule

@@ rtl/ccell_dp.sv @@
// datapath: configuration, cell memories, update pipeline and result register
module ccell_dp
    import ccell_pkg::*;
#(
    parameter int NUM_CELLS = 32,
    parameter int CW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  ccell_cmd_t           cmd,
    input  logic [CW-1:0]        cell_idx,
    output ccell_sts_t           sts,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [15:0]          step_index,
    output logic signed [31:0]   watched_voltage,
    output logic signed [31:0]   watched_gate
);

    localparam int SH_UP = (FRAC_BITS >= 24) ? FRAC_BITS - 24 : 0;
    localparam int SH_DN = (FRAC_BITS >= 24) ? 0 : 24 - FRAC_BITS;
    localparam logic signed [31:0] ONE = 32'(64'd1 << FRAC_BITS);
    localparam logic signed [31:0] THR =
        32'((64'd13 * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic signed [31:0] INIT_V = (INIT_V_Q24 << SH_UP) >> SH_DN;
    localparam logic signed [31:0] INIT_H = (INIT_H_Q24 << SH_UP) >> SH_DN;
    localparam int S_WB = 14;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (x < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

    // product scaled back by the fraction bits, truncated toward zero
    function automatic logic signed [31:0] fx_trunc(input logic signed [63:0] p);
        logic signed [63:0] bias;
        bias = p[63] ? $signed((64'd1 << FRAC_BITS) - 64'd1) : 64'sd0;
        return sat32((p + bias) >>> FRAC_BITS);
    endfunction

    // truncated 10*r/3 for a remainder of a divide by three
    function automatic logic signed [35:0] third_corr(input logic signed [2:0] r);
        logic signed [35:0] c;
        case (r)
            3'sd2:   c = 36'sd6;
            3'sd1:   c = 36'sd3;
            -3'sd1:  c = -36'sd3;
            -3'sd2:  c = -36'sd6;
            default: c = 36'sd0;
        endcase
        return c;
    endfunction

    // configuration
    logic [15:0]        stim_first_reg;
    logic [15:0]        stim_last_reg;
    logic [5:0]         stim_cells_reg;
    logic signed [31:0] stim_amp_reg;
    logic [24:0]        time_step_reg;
    logic [4:0]         watch_cell_reg;

    // tick state
    logic        fresh_reg;
    logic [15:0] step_cnt_reg;

    // cell memories
    logic [31:0] v_mem [NUM_CELLS];
    logic [31:0] h_mem [NUM_CELLS];
    logic [31:0] v_rd_reg;
    logic [31:0] h_rd_reg;

    // result register
    logic               out_valid_reg;
    logic [15:0]        step_index_reg;
    logic signed [31:0] watched_v_reg;
    logic signed [31:0] watched_h_reg;

    // update pipeline
    logic [S_WB:0]      vld_reg;
    logic [CW-1:0]      idx_dly_reg  [0:S_WB];
    logic               stim_dly_reg [0:11];
    logic signed [31:0] v_dly_reg    [1:S_WB];
    logic signed [31:0] h_dly_reg    [1:S_WB];
    logic signed [31:0] omv_dly_reg  [1:4];
    logic               cond_dly_reg [1:4];
    logic signed [31:0] jout_dly_reg [4:11];
    logic signed [31:0] dh_dly_reg   [5:12];
    logic signed [31:0] p_dly_reg    [7:9];
    logic signed [63:0] vv_prod1_reg;
    logic signed [31:0] omh1_reg;
    logic signed [31:0] vv2_reg;
    logic signed [63:0] hvv_prod3_reg;
    logic signed [31:0] hvv4_reg;
    logic signed [63:0] p_prod5_reg;
    logic signed [31:0] p6_reg;
    logic signed [2:0]  r10_reg;
    logic signed [35:0] tq10_reg;
    logic signed [31:0] jin11_reg;
    logic signed [31:0] dv12_reg;
    logic signed [63:0] dtdv13_reg;
    logic signed [63:0] dtdh13_reg;
    logic signed [31:0] fdv14_reg;
    logic signed [31:0] fdh14_reg;

    logic signed [31:0] q6;
    logic signed [31:0] q120;
    logic signed [31:0] q150;
    logic signed [31:0] q3;

    logic               in_window;
    logic               stim_flag;
    logic               watch_in_range;
    logic [CW-1:0]      watch_addr;
    logic [CW-1:0]      rd_addr;
    logic               rd_en;
    logic signed [31:0] v0;
    logic signed [31:0] h0;
    logic signed [31:0] stim_amt;
    logic signed [25:0] dt_s;
    logic signed [31:0] nv;
    logic signed [31:0] nh;

    always_comb
    begin
        in_window      = (step_cnt_reg >= stim_first_reg) && (step_cnt_reg <= stim_last_reg);
        stim_flag      = in_window && (16'(cell_idx) < 16'(stim_cells_reg));
        watch_in_range = 16'(watch_cell_reg) < 16'(NUM_CELLS);
        watch_addr     = CW'(watch_cell_reg);
        rd_en          = cmd.rd_watch || cmd.rd_cell;
        rd_addr        = cmd.rd_watch ? watch_addr : cell_idx;
        // cells still hold the initial values until a full step has been written
        v0             = fresh_reg ? INIT_V : $signed(v_rd_reg);
        h0             = fresh_reg ? INIT_H : $signed(h_rd_reg);
        stim_amt       = stim_dly_reg[11] ? stim_amp_reg : 32'sd0;
        dt_s           = $signed({1'b0, time_step_reg});
        nv             = sat32(64'(v_dly_reg[S_WB]) + 64'(fdv14_reg));
        nh             = sat32(64'(h_dly_reg[S_WB]) + 64'(fdh14_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stim_first_reg <= STIM_FIRST_RST;
            stim_last_reg  <= STIM_LAST_RST;
            stim_cells_reg <= STIM_CELLS_RST;
            stim_amp_reg   <= STIM_AMP_RST;
            time_step_reg  <= TIME_STEP_RST;
            watch_cell_reg <= WATCH_CELL_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_STIM_FIRST: stim_first_reg <= cfg_data[15:0];
                CFG_STIM_LAST:  stim_last_reg  <= cfg_data[15:0];
                CFG_STIM_CELLS: stim_cells_reg <= cfg_data[5:0];
                CFG_STIM_AMP:   stim_amp_reg   <= cfg_data;
                CFG_TIME_STEP:  time_step_reg  <= cfg_data[24:0];
                CFG_WATCH_CELL: watch_cell_reg <= cfg_data[4:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg     <= 1'b1;
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            if (cmd.load_init)
            begin
                fresh_reg    <= 1'b1;
                step_cnt_reg <= '0;
            end
            else if (cmd.finish)
            begin
                fresh_reg <= 1'b0;
                if (step_cnt_reg != 16'hffff)
                begin
                    step_cnt_reg <= step_cnt_reg + 16'd1;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            vld_reg <= {vld_reg[S_WB-1:0], cmd.rd_cell};
        end
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg[S_WB])
        begin
            v_mem[idx_dly_reg[S_WB]] <= nv;
            h_mem[idx_dly_reg[S_WB]] <= nh;
        end
        if (rd_en)
        begin
            v_rd_reg <= v_mem[rd_addr];
            h_rd_reg <= h_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            step_index_reg <= step_cnt_reg;
            watched_v_reg  <= watch_in_range ? v0 : 32'sd0;
            watched_h_reg  <= watch_in_range ? h0 : 32'sd0;
        end
    end

    // side data follows each cell down the pipeline
    always_ff @(posedge clk)
    begin
        idx_dly_reg[0]  <= cell_idx;
        stim_dly_reg[0] <= stim_flag;
        for (int k = 1; k <= S_WB; k++)
        begin
            idx_dly_reg[k] <= idx_dly_reg[k-1];
        end
        for (int k = 1; k <= 11; k++)
        begin
            stim_dly_reg[k] <= stim_dly_reg[k-1];
        end
        v_dly_reg[1] <= v0;
        h_dly_reg[1] <= h0;
        for (int k = 2; k <= S_WB; k++)
        begin
            v_dly_reg[k] <= v_dly_reg[k-1];
            h_dly_reg[k] <= h_dly_reg[k-1];
        end
        omv_dly_reg[1]  <= sat32(64'(ONE) - 64'(v0));
        cond_dly_reg[1] <= v0 < THR;
        for (int k = 2; k <= 4; k++)
        begin
            omv_dly_reg[k]  <= omv_dly_reg[k-1];
            cond_dly_reg[k] <= cond_dly_reg[k-1];
        end
        jout_dly_reg[4] <= -q6;
        for (int k = 5; k <= 11; k++)
        begin
            jout_dly_reg[k] <= jout_dly_reg[k-1];
        end
        dh_dly_reg[5] <= cond_dly_reg[4] ? q120 : -q150;
        for (int k = 6; k <= 12; k++)
        begin
            dh_dly_reg[k] <= dh_dly_reg[k-1];
        end
        p_dly_reg[7] <= p6_reg;
        p_dly_reg[8] <= p_dly_reg[7];
        p_dly_reg[9] <= p_dly_reg[8];
    end

    // inward current, then the euler updates
    always_ff @(posedge clk)
    begin
        vv_prod1_reg  <= 64'(v0) * 64'(v0);
        omh1_reg      <= sat32(64'(ONE) - 64'(h0));
        vv2_reg       <= fx_trunc(vv_prod1_reg);
        hvv_prod3_reg <= 64'(h_dly_reg[2]) * 64'(vv2_reg);
        hvv4_reg      <= fx_trunc(hvv_prod3_reg);
        p_prod5_reg   <= 64'(hvv4_reg) * 64'(omv_dly_reg[4]);
        p6_reg        <= fx_trunc(p_prod5_reg);
        r10_reg       <= 3'(p_dly_reg[9] - q3 * 32'sd3);
        tq10_reg      <= 36'(q3) * 36'sd10;
        jin11_reg     <= sat32(64'(tq10_reg + third_corr(r10_reg)));
        dv12_reg      <= sat32(64'(jin11_reg) + 64'(jout_dly_reg[11]) + 64'(stim_amt));
        dtdv13_reg    <= 64'(dt_s) * 64'(dv12_reg);
        dtdh13_reg    <= 64'(dt_s) * 64'(dh_dly_reg[12]);
        fdv14_reg     <= fx_trunc(dtdv13_reg);
        fdh14_reg     <= fx_trunc(dtdh13_reg);
    end

    ccell_cdiv #(.DIVISOR(6)) u_div6 (
        .clk (clk),
        .x   (v0),
        .q   (q6)
    );

    ccell_cdiv #(.DIVISOR(120)) u_div120 (
        .clk (clk),
        .x   (omh1_reg),
        .q   (q120)
    );

    ccell_cdiv #(.DIVISOR(150)) u_div150 (
        .clk (clk),
        .x   (h_dly_reg[1]),
        .q   (q150)
    );

    ccell_cdiv #(.DIVISOR(3)) u_div3 (
        .clk (clk),
        .x   (p6_reg),
        .q   (q3)
    );

    assign sts.pipe_busy   = |vld_reg;
    assign sts.out_free    = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign step_index      = step_index_reg;
    assign watched_voltage = watched_v_reg;
    assign watched_gate    = watched_h_reg;

`ifndef ASSERT_OFF
    a_watch_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_watch |-> (vld_reg == '0))
        else $error("watched read issued while cell updates are in flight");
    a_step_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_init || cmd.finish) |=> $stable(step_cnt_reg))
        else $error("step count moved outside a tick boundary");
`endif

endmodule

@@ test/cardiac_cell_euler_step_tb.sv @@
// testbench of the cardiac cell euler step block: scripted and random ticks vs a cell model
`timescale 1ns / 100ps

module cardiac_cell_euler_step_tb;
    import ccell_pkg::*;

    localparam int NUM_CELLS = 32;
    localparam longint FX_ONE = longint'(1) << FRAC_BITS;
    localparam longint V_THRESH = (13 * FX_ONE + 50) / 100;
    localparam longint INIT_V = (FRAC_BITS >= 24) ? (longint'(INIT_V_Q24) << (FRAC_BITS - 24))
                                                  : (longint'(INIT_V_Q24) >> (24 - FRAC_BITS));
    localparam longint INIT_H = (FRAC_BITS >= 24) ? (longint'(INIT_H_Q24) << (FRAC_BITS - 24))
                                                  : (longint'(INIT_H_Q24) >> (24 - FRAC_BITS));
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int QUIET_CYCLES = 2 * NUM_CELLS + 40;
    localparam int LONG_HOLD = 400;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_TICKS = 200;
    localparam int TAIL_TICKS = 60;
    localparam longint LIMIT_NS = 20_000_000;

    typedef struct packed {
        logic [15:0] step;
        logic [31:0] volt;
        logic [31:0] gate;
    } tick_report_t;

    typedef enum logic {ROW_TICK, ROW_SETTING} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [31:0]            data;
        logic                   rst_bit;
        logic                   typed;
        tick_report_t           want;
    } script_row_t;

    localparam tick_report_t NO_REPORT = '0;
    localparam tick_report_t INIT_REPORT = '{16'd0, 32'(INIT_V), 32'(INIT_H)};

    localparam int NUM_DIR = 34;
    localparam script_row_t DIR_ROWS [NUM_DIR] = '{
        '{ROW_TICK,    CFG_STIM_FIRST, 32'h0000_0000, 1'b0, 1'b1, INIT_REPORT},
        '{ROW_TICK,    CFG_STIM_FIRST, 32'h0000_0000, 1'b0, 1'b0, NO_REPORT},
        '{ROW_TICK,    CFG_STIM_FIRST, 32'h0000_0000, 1'b1, 1'b1, INIT_REPORT},
        '{ROW_TICK,    CFG_STIM_FIRST, 32'h0000_0000, 1'b1, 1'b1, INIT_REPORT},
        '{ROW_SETTING, CFG_WATCH_CELL, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_REPORT},
        '{ROW_TICK,    CFG_STIM_FIRST, 32'h0000_0000, 1'b0, 1'b1, INIT_REPORT},
        '{ROW_SETTING, CFG_TIME_STEP,  32'hFFFF_FFFF, 1'b0, 1'b0, NO_REPORT},
        '{ROW_SETTING, CFG_STIM_AMP,   32'h7FFF_FFFF, 1'b0, 1'b0, NO_REPORT},
        '{ROW_SETTING, CFG_STIM_CELLS, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_REPORT},
        '{ROW_SETTING, CFG_STIM_LAST,  32'hFFFF_FFFF, 1'b0, 1'b0, NO_REPORT},
        '{ROW_TICK,    CFG_STIM_FIRST, 32'h0000_0000, 1'b0, 1'b0, NO_REPORT},
        '{ROW_TICK,    CFG_STIM_FIRST, 32'h0000_0000, 1'b0, 1'b0, NO_REPORT},
        '{ROW_SETTING, CFG_STIM_AMP,   32'h8000_0000, 1'b0, 1'b0, NO_REPORT},
        '{ROW_TICK,    CFG_STIM_FIRST, 32'h0000_0000, 1'b0, 1'b0, NO_REPORT},
        '{ROW_TICK,    CFG_STIM_FIRST, 32'h0000_0000, 1'b0, 1'b0, NO_REPORT},
        '{ROW_SETTING, CFG_STIM_FIRST, 32'h0000_0009, 1'b0, 1'b0, NO_REPORT},
        '{ROW_SETTING, CFG_STIM_LAST,  32'hABCD_0003, 1'b0, 1'b0, NO_REPORT},
        '{ROW_SETTING, CFG_SPARE_LO,   32'hFFFF_FFFF, 1'b0, 1'b0, NO_REPORT},
        '{ROW_SETTING, CFG_SPARE_HI,   32'hFFFF_FFFF, 1'b0, 1'b0, NO_REPORT},
        '{ROW_TICK,    CFG_STIM_FIRST, 32'h0000_0000, 1'b0, 1'b0, NO_REPORT},
        '{ROW_SETTING, CFG_STIM_CELLS, 32'h0000_0000, 1'b0, 1'b0, NO_REPORT},
        '{ROW_SETTING, CFG_TIME_STEP,  32'h0000_0000, 1'b0, 1'b0, NO_REPORT},
        '{ROW_TICK,    CFG_STIM_FIRST, 32'h0000_0000, 1'b0, 1'b0, NO_REPORT},
        '{ROW_SETTING, CFG_WATCH_CELL, 32'h0000_0000, 1'b0, 1'b0, NO_REPORT},
        '{ROW_SETTING, CFG_TIME_STEP,  32'h0100_0000, 1'b0, 1'b0, NO_REPORT},
        '{ROW_SETTING, CFG_STIM_FIRST, 32'hFFFF_0000, 1'b0, 1'b0, NO_REPORT},
        '{ROW_TICK,    CFG_STIM_FIRST, 32'h0000_0000, 1'b1, 1'b1, INIT_REPORT},
        '{ROW_TICK,    CFG_STIM_FIRST, 32'h0000_0000, 1'b0, 1'b0, NO_REPORT},
        '{ROW_SETTING, CFG_STIM_CELLS, 32'h0000_0020, 1'b0, 1'b0, NO_REPORT},
        '{ROW_SETTING, CFG_STIM_AMP,   32'h0100_0000, 1'b0, 1'b0, NO_REPORT},
        '{ROW_TICK,    CFG_STIM_FIRST, 32'h0000_0000, 1'b0, 1'b0, NO_REPORT},
        '{ROW_TICK,    CFG_STIM_FIRST, 32'h0000_0000, 1'b0, 1'b0, NO_REPORT},
        '{ROW_TICK,    CFG_STIM_FIRST, 32'h0000_0000, 1'b0, 1'b0, NO_REPORT},
        '{ROW_TICK,    CFG_STIM_FIRST, 32'h0000_0000, 1'b0, 1'b0, NO_REPORT}
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   restart;
    logic                   out_valid;
    logic                   out_ready;
    logic [15:0]            step_index;
    logic signed [31:0]     watched_voltage;
    logic signed [31:0]     watched_gate;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [31:0]            cfg_data;

    // model state and settings
    logic signed [31:0] cell_v [NUM_CELLS];
    logic signed [31:0] cell_h [NUM_CELLS];
    logic [15:0]        tick_count;
    logic [15:0]        cfg_first;
    logic [15:0]        cfg_last;
    logic [5:0]         cfg_cells;
    logic signed [31:0] cfg_amp;
    logic [24:0]        cfg_dt;
    logic [4:0]         cfg_watch;

    tick_report_t report_q[$];
    int  fail_cnt = 0;
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    logic hold_req = 1'b0;

    cardiac_cell_euler_step #(
        .NUM_CELLS(NUM_CELLS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .restart(restart),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .step_index(step_index),
        .watched_voltage(watched_voltage),
        .watched_gate(watched_gate),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint clamp32(input longint x);
        if (x > S32_MAX)
            return S32_MAX;
        if (x < S32_MIN)
            return S32_MIN;
        return x;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return clamp32((a * b) / FX_ONE);
    endfunction

    function automatic void reload_cells();
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            cell_v[i] = 32'(INIT_V);
            cell_h[i] = 32'(INIT_H);
        end
        tick_count = '0;
    endfunction

    // one euler step of every cell, or a reload when rst_bit is set; returns the watched cell as it was before
    function automatic tick_report_t advance_cells(input logic rst_bit);
        tick_report_t rep;
        logic   in_window;
        longint v, h, stim, vv, hvv, omv, jin, jout, dv, dh, nv, nh;
        longint dt;
        if (rst_bit)
            reload_cells();
        rep.step = tick_count;
        if (cfg_watch < NUM_CELLS)
        begin
            rep.volt = cell_v[cfg_watch];
            rep.gate = cell_h[cfg_watch];
        end
        else
        begin
            rep.volt = '0;
            rep.gate = '0;
        end
        if (rst_bit)
            return rep;
        dt = longint'(cfg_dt);
        in_window = (tick_count >= cfg_first) && (tick_count <= cfg_last);
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            v = cell_v[i];
            h = cell_h[i];
            stim = (in_window && i < cfg_cells) ? longint'(cfg_amp) : 0;
            vv = fx_mul(v, v);
            hvv = fx_mul(h, vv);
            omv = clamp32(FX_ONE - v);
            jin = clamp32(fx_mul(hvv, omv) * 10 / 3);
            jout = -(v / 6);
            dv = clamp32(jin + jout + stim);
            dh = (v < V_THRESH) ? clamp32(FX_ONE - h) / 120 : -(h / 150);
            nv = clamp32(v + fx_mul(dt, dv));
            nh = clamp32(h + fx_mul(dt, dh));
            cell_v[i] = nv[31:0];
            cell_h[i] = nh[31:0];
        end
        if (tick_count != 16'hFFFF)
            tick_count = tick_count + 16'd1;
        return rep;
    endfunction

    function automatic int pick_gap();
        int g;
        g = 0;
        while (g < 200 && $urandom_range(99) < tx_idle_pct)
            g++;
        return g;
    endfunction

    // random junk above the register width, masked off by the block
    function automatic logic [31:0] with_junk(input logic [31:0] value, input int width);
        logic [31:0] junk;
        junk = $urandom_range(1) ? $urandom() : 32'd0;
        if (width >= 32)
            return value;
        return (junk << width) | value;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_tick(input logic rst_bit, input int gap, input logic typed,
                             input tick_report_t typed_want);
        tick_report_t want;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        restart = rst_bit;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        want = advance_cells(rst_bit);
        report_q.push_back(typed ? typed_want : want);
        @(negedge clk);
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_STIM_FIRST: cfg_first = data[15:0];
            CFG_STIM_LAST:  cfg_last = data[15:0];
            CFG_STIM_CELLS: cfg_cells = data[5:0];
            CFG_STIM_AMP:   cfg_amp = data;
            CFG_TIME_STEP:  cfg_dt = data[24:0];
            CFG_WATCH_CELL: cfg_watch = data[4:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // wait until the block has finished every tick
    task automatic settle_block();
        in_valid = 1'b0;
        cfg_valid = 1'b0;
        wait (report_q.size() == 0);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    // receiver ready with random stalls and a long hold-off
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
                out_ready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // result checker
    initial
    begin
        tick_report_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (report_q.size() == 0)
                begin
                    $error("unexpected result item, step_index %0d", step_index);
                    fail_cnt++;
                end
                else
                begin
                    want = report_q.pop_front();
                    check_field("step_index", longint'(want.step), longint'(step_index));
                    check_field("watched_voltage", longint'($signed(want.volt)),
                                longint'(watched_voltage));
                    check_field("watched_gate", longint'($signed(want.gate)),
                                longint'(watched_gate));
                end
            end
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("cardiac_cell_euler_step verification failed");
        $finish;
    end

    initial
    begin
        logic [15:0] first;
        logic [15:0] last;
        rst_n = 1'b0;
        in_valid = 1'b0;
        restart = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_STIM_FIRST;
        cfg_data = '0;
        cfg_first = STIM_FIRST_RST;
        cfg_last = STIM_LAST_RST;
        cfg_cells = STIM_CELLS_RST;
        cfg_amp = STIM_AMP_RST;
        cfg_dt = TIME_STEP_RST;
        cfg_watch = WATCH_CELL_RST;
        reload_cells();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed script
        for (int r = 0; r < NUM_DIR; r++)
        begin
            if (DIR_ROWS[r].kind == ROW_SETTING)
            begin
                if (r > 0 && DIR_ROWS[r-1].kind == ROW_TICK)
                    settle_block();
                write_setting(DIR_ROWS[r].idx, DIR_ROWS[r].data);
            end
            else
            begin
                cfg_valid = 1'b0;
                send_tick(DIR_ROWS[r].rst_bit, 0, DIR_ROWS[r].typed, DIR_ROWS[r].want);
            end
        end

        // random phases with different idle patterns and settings
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle_block();
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 85; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 85; end
                default: begin tx_idle_pct = 25; rx_stall_pct = 25; end
            endcase
            first = 16'($urandom_range(0, 200));
            last = ($urandom_range(7) == 0) ? 16'($urandom_range(0, 65535))
                                            : 16'(first + $urandom_range(0, 400));
            write_setting(CFG_STIM_FIRST, with_junk(32'(first), 16));
            write_setting(CFG_STIM_LAST, with_junk(32'(last), 16));
            write_setting(CFG_STIM_CELLS, with_junk(32'($urandom_range(0, 63)), 6));
            write_setting(CFG_STIM_AMP, ($urandom_range(3) == 0) ? $urandom()
                          : 32'($urandom_range(0, 2**26) - 2**25));
            write_setting(CFG_TIME_STEP, with_junk(($urandom_range(5) == 0)
                          ? 32'($urandom_range(0, 2**25 - 1))
                          : 32'($urandom_range(0, 2**23)), 25));
            write_setting(CFG_WATCH_CELL, with_junk(32'($urandom_range(0, 31)), 5));
            cfg_valid = 1'b0;
            send_tick(1'b1, 0, 1'b0, NO_REPORT);
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                if (p == 0 && n == 60)
                    hold_req = 1'b1;
                if (p == 0 && n == 140)
                begin
                    in_valid = 1'b0;
                    wait (report_q.size() == 0);
                    @(negedge clk);
                end
                send_tick($urandom_range(63) == 0, pick_gap(), 1'b0, NO_REPORT);
            end
        end

        // stimulate every cell over a window open up to the top step index
        settle_block();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        write_setting(CFG_STIM_FIRST, 32'd20);
        write_setting(CFG_STIM_LAST, 32'hFFFF_FFFF);
        write_setting(CFG_STIM_CELLS, 32'd32);
        write_setting(CFG_STIM_AMP, 32'h0080_0000);
        write_setting(CFG_TIME_STEP, 32'd167772);
        write_setting(CFG_WATCH_CELL, 32'($urandom_range(0, 31)));
        cfg_valid = 1'b0;
        send_tick(1'b1, 0, 1'b0, NO_REPORT);
        for (int n = 0; n < TAIL_TICKS; n++)
            send_tick(1'b0, 0, 1'b0, NO_REPORT);
        send_tick(1'b1, 0, 1'b1, INIT_REPORT);

        in_valid = 1'b0;
        wait (report_q.size() == 0);
        repeat (QUIET_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("cardiac_cell_euler_step verification clean");
        else
            $display("cardiac_cell_euler_step verification failed");
        $finish;
    end

endmodule
